@@ src/sva_pkg.sv @@
// ----------------------------------------------------------------------------
// sva_pkg
// Shared types, codes and constants for the voice allocator: message codes,
// result codes, sequencer states and the control structs between its parts.
// ----------------------------------------------------------------------------
package sva_pkg;

	// Sizes fixed by the word formats
	localparam int VOICES_DEF = 16;
	localparam int IDX_W      = 4;
	localparam int NOTE_W     = 7;
	localparam int VEL_W      = 7;
	localparam int MASK_W     = 16;
	localparam int STAMP_W    = 64;
	localparam int CFG_W      = 5;
	localparam int CNT_W      = 5;

	localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

	// Upper nibble of the status byte
	localparam logic [3:0] ST_NOTE_OFF = 4'h8;
	localparam logic [3:0] ST_NOTE_ON  = 4'h9;
	localparam logic [3:0] ST_CTRL     = 4'hB;

	// Controllers that release every voice
	localparam logic [NOTE_W-1:0] CC_ALL_SOUND_OFF = 7'd120;
	localparam logic [NOTE_W-1:0] CC_ALL_NOTES_OFF = 7'd123;

	// Full message length code
	localparam logic [1:0] LEN_FULL = 2'd3;

	typedef enum logic [1:0] {
		ACT_NONE    = 2'd0,
		ACT_START   = 2'd1,
		ACT_RELEASE = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		KIND_FREE      = 2'd0,
		KIND_RETRIG    = 2'd1,
		KIND_STEAL_REL = 2'd2,
		KIND_STEAL_OLD = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_WRAP,
		S_EMIT
	} alloc_state_t;

	// Updates requested from the voice file
	typedef struct packed {
		logic              launch;
		logic [IDX_W-1:0]  launch_idx;
		logic [NOTE_W-1:0] launch_note;
		logic              rel_one;
		logic [IDX_W-1:0]  rel_idx;
		logic              rel_all;
		logic              finish;
		logic [IDX_W-1:0]  finish_idx;
	} vf_cmd_t;

	// One voice as read at the scan index
	typedef struct packed {
		logic               active;
		logic               releasing;
		logic [NOTE_W-1:0]  note;
		logic [STAMP_W-1:0] stamp;
	} voice_rd_t;

	// Scan sequencing
	typedef struct packed {
		logic clear;
		logic step;
		logic note_on;
	} scan_ctl_t;

	// Accumulated scan outcome
	typedef struct packed {
		logic             match_found;
		logic [IDX_W-1:0] match_idx;
		logic             free_found;
		logic [IDX_W-1:0] free_idx;
		logic             old_found;
		logic [IDX_W-1:0] old_idx;
		logic [CNT_W-1:0] count;
	} scan_res_t;

	// Bits needed to index a voice
	function automatic int idx_width(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

@@ src/sva_in_if.sv @@
// ----------------------------------------------------------------------------
// sva_in_if
// Input channel: one MIDI message or voice-finished event per word.
// ----------------------------------------------------------------------------
interface sva_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] status_byte;
	logic [7:0] data_one;
	logic [7:0] data_two;
	logic [1:0] msg_length;
	logic [3:0] finished_voice;

	modport source (
		output valid, command, status_byte, data_one, data_two, msg_length,
			finished_voice,
		input  ready
	);
	modport sink (
		input  valid, command, status_byte, data_one, data_two, msg_length,
			finished_voice,
		output ready
	);
endinterface

@@ src/sva_out_if.sv @@
// ----------------------------------------------------------------------------
// sva_out_if
// Result channel: one allocation decision per word.
// ----------------------------------------------------------------------------
interface sva_out_if import sva_pkg::*; ();
	logic              valid;
	logic              ready;
	action_t           action;
	logic [IDX_W-1:0]  voice_index;
	logic [NOTE_W-1:0] note_number;
	logic [VEL_W-1:0]  strike_velocity;
	kind_t             start_kind;
	logic [MASK_W-1:0] release_mask;

	modport source (
		output valid, action, voice_index, note_number, strike_velocity, start_kind,
			release_mask,
		input  ready
	);
	modport sink (
		input  valid, action, voice_index, note_number, strike_velocity, start_kind,
			release_mask,
		output ready
	);
endinterface

@@ src/sva_cfg_if.sv @@
// ----------------------------------------------------------------------------
// sva_cfg_if
// Configuration write channel for the voice cap register.
// ----------------------------------------------------------------------------
interface sva_cfg_if import sva_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

@@ src/sva_voice_file.sv @@
// ----------------------------------------------------------------------------
// sva_voice_file
// Per-voice state: active and releasing flags, held note, start stamp, and
// the start counter. One voice is read per cycle at the scan index.
// ----------------------------------------------------------------------------
module sva_voice_file import sva_pkg::*; #(
	parameter int VOICES = VOICES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  vf_cmd_t                       cmd,
	input  logic [idx_width(VOICES)-1:0]  rd_idx,
	output voice_rd_t                     rd,
	output logic [VOICES-1:0]             active,
	output logic [VOICES-1:0]             releasing
);
	localparam int VW = idx_width(VOICES);

	logic [VOICES-1:0]  active_q;
	logic [VOICES-1:0]  rel_q;
	logic [NOTE_W-1:0]  note_q  [VOICES];
	logic [STAMP_W-1:0] stamp_q [VOICES];
	logic [STAMP_W-1:0] counter_q;
	logic [STAMP_W-1:0] stamp_next;
	logic [VW-1:0]      launch_i;
	logic [VW-1:0]      rel_i;
	logic [VW-1:0]      fin_i;

	assign launch_i   = cmd.launch_idx[VW-1:0];
	assign rel_i      = cmd.rel_idx[VW-1:0];
	assign fin_i      = cmd.finish_idx[VW-1:0];
	assign stamp_next = counter_q + STAMP_W'(1);

	// Update flags and counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '0;
			rel_q     <= '0;
			counter_q <= '0;
		end else begin
			if (cmd.launch) begin
				active_q[launch_i] <= 1'b1;
				rel_q[launch_i]    <= 1'b0;
				counter_q          <= stamp_next;
			end
			if (cmd.rel_one) begin
				rel_q[rel_i] <= 1'b1;
			end
			if (cmd.rel_all) begin
				rel_q <= rel_q | active_q;
			end
			if (cmd.finish && active_q[fin_i] && rel_q[fin_i]) begin
				active_q[fin_i] <= 1'b0;
				rel_q[fin_i]    <= 1'b0;
			end
		end
	end

	// Store note and stamp of a started voice
	always_ff @(posedge clk) begin
		if (cmd.launch) begin
			note_q[launch_i]  <= cmd.launch_note;
			stamp_q[launch_i] <= stamp_next;
		end
	end

	// Read one voice
	always_comb begin
		rd.active    = active_q[rd_idx];
		rd.releasing = rel_q[rd_idx];
		rd.note      = note_q[rd_idx];
		rd.stamp     = stamp_q[rd_idx];
	end

	assign active    = active_q;
	assign releasing = rel_q;

endmodule

@@ src/sva_scan_unit.sv @@
// ----------------------------------------------------------------------------
// sva_scan_unit
// Walks the voices one per cycle with a single note compare and a single
// stamp compare. Note-on scans collect the retrigger match, the lowest free
// voice, the active count and the oldest steal candidate; note-off scans
// flag matching voices and build the release mask.
// ----------------------------------------------------------------------------
module sva_scan_unit import sva_pkg::*; #(
	parameter int VOICES = VOICES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  scan_ctl_t                     ctl,
	input  logic [NOTE_W-1:0]             key_note,
	input  logic                          any_rel,
	input  voice_rd_t                     rd,
	output logic [idx_width(VOICES)-1:0]  scan_idx,
	output logic                          last,
	output logic                          hit,
	output scan_res_t                     res,
	output logic [VOICES-1:0]             mask
);
	localparam int VW = idx_width(VOICES);
	localparam int CW = $clog2(VOICES + 1);

	logic [VW-1:0]      idx_q;
	logic               match_found_q;
	logic [VW-1:0]      match_idx_q;
	logic               free_found_q;
	logic [VW-1:0]      free_idx_q;
	logic               old_found_q;
	logic [VW-1:0]      old_idx_q;
	logic [STAMP_W-1:0] old_stamp_q;
	logic [CW-1:0]      count_q;
	logic [VOICES-1:0]  mask_q;
	logic               note_eq;
	logic               candidate;
	logic               take_old;

	assign last      = idx_q == VW'(VOICES - 1);
	assign note_eq   = rd.note == key_note;
	assign hit       = ctl.step && !ctl.note_on && rd.active && note_eq;
	// Steal from releasing voices when any exist, else from all active ones
	assign candidate = rd.active && (!any_rel || rd.releasing);
	assign take_old  = ctl.step && ctl.note_on && candidate &&
		(!old_found_q || (rd.stamp < old_stamp_q));

	// Advance the index and accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q         <= '0;
			match_found_q <= 1'b0;
			match_idx_q   <= '0;
			free_found_q  <= 1'b0;
			free_idx_q    <= '0;
			old_found_q   <= 1'b0;
			old_idx_q     <= '0;
			count_q       <= '0;
			mask_q        <= '0;
		end else if (ctl.clear) begin
			idx_q         <= '0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			old_found_q   <= 1'b0;
			count_q       <= '0;
			mask_q        <= '0;
		end else if (ctl.step) begin
			idx_q <= idx_q + VW'(1);
			if (ctl.note_on) begin
				if (rd.active) begin
					count_q <= count_q + CW'(1);
					if (!match_found_q && note_eq) begin
						match_found_q <= 1'b1;
						match_idx_q   <= idx_q;
					end
				end else if (!free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= idx_q;
				end
				if (take_old) begin
					old_found_q <= 1'b1;
					old_idx_q   <= idx_q;
				end
			end else if (hit) begin
				mask_q[idx_q] <= 1'b1;
			end
		end
	end

	// Hold the oldest stamp seen so far
	always_ff @(posedge clk) begin
		if (take_old) begin
			old_stamp_q <= rd.stamp;
		end
	end

	always_comb begin
		res.match_found = match_found_q;
		res.match_idx   = IDX_W'(match_idx_q);
		res.free_found  = free_found_q;
		res.free_idx    = IDX_W'(free_idx_q);
		res.old_found   = old_found_q;
		res.old_idx     = IDX_W'(old_idx_q);
		res.count       = CNT_W'(count_q);
	end

	assign scan_idx = idx_q;
	assign mask     = mask_q;

endmodule

@@ src/synth_voice_allocator.sv @@
// ----------------------------------------------------------------------------
// synth_voice_allocator
// Polyphonic voice allocator with oldest-note stealing.
//
// Usage:
//   in_ch carries one MIDI message (command 0) or voice-finished event
//   (command 1) per word; out_ch returns exactly one result word for each.
//   cfg_ch writes the voice cap; it is always ready and should be written
//   only while no message is in flight.
// Sequencing:
//   Note-on and note-off messages scan the voices one per cycle through a
//   single note and stamp comparator; the pending result is registered in
//   S_WRAP and moved to the output register in S_EMIT once that register is
//   free, and no new word is taken before that move.
//   Finished events, controller releases and ignored messages skip the scan
//   and go straight to S_EMIT.
// Reset:
//   All voices idle, start counter zero, voice cap 16; no result pending.
// Backpressure:
//   A result waits in the output register while out_ch.ready is low; the
//   next word is taken and processed meanwhile, then holds until the
//   output register is free.
// ----------------------------------------------------------------------------
module synth_voice_allocator import sva_pkg::*; #(
	parameter int VOICES = VOICES_DEF
) (
	input logic       clk,
	input logic       arst_n,
	sva_in_if.sink    in_ch,
	sva_out_if.source out_ch,
	sva_cfg_if.sink   cfg_ch
);
	localparam int VW = idx_width(VOICES);

	alloc_state_t      state_q;
	alloc_state_t      state_d;
	logic              mode_on_q;
	logic [NOTE_W-1:0] d1_q;
	logic [VEL_W-1:0]  d2_q;
	logic [CFG_W-1:0]  cap_q;

	action_t           res_action_q;
	logic [IDX_W-1:0]  res_idx_q;
	logic [NOTE_W-1:0] res_note_q;
	logic [VEL_W-1:0]  res_vel_q;
	kind_t             res_kind_q;
	logic [MASK_W-1:0] res_mask_q;

	logic              out_valid_q;
	action_t           out_action_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [NOTE_W-1:0] out_note_q;
	logic [VEL_W-1:0]  out_vel_q;
	kind_t             out_kind_q;
	logic [MASK_W-1:0] out_mask_q;

	vf_cmd_t           vf_cmd;
	voice_rd_t         vf_rd;
	logic [VOICES-1:0] vf_active;
	logic [VOICES-1:0] vf_rel;
	scan_ctl_t         scan_ctl;
	scan_res_t         scan_res;
	logic [VW-1:0]     scan_idx;
	logic              scan_last;
	logic              scan_hit;
	logic [VOICES-1:0] scan_mask;

	logic              in_ready;
	logic              accept;
	logic              out_free;
	logic [3:0]        status_hi;
	logic [NOTE_W-1:0] in_d1;
	logic [VEL_W-1:0]  in_d2;
	logic              len_ok;
	logic              msg_on;
	logic              msg_off;
	logic              msg_all;
	logic              fin_ok;
	logic              any_rel;
	logic [CFG_W-1:0]  cap_eff;
	logic              pick_ok;
	logic [IDX_W-1:0]  pick_idx;
	kind_t             pick_kind;
	logic [VW-1:0]     launch_i;

	// Decode the incoming word
	assign status_hi = in_ch.status_byte[7:4];
	assign in_d1     = in_ch.data_one[NOTE_W-1:0];
	assign in_d2     = in_ch.data_two[VEL_W-1:0];
	assign len_ok    = !in_ch.command && (in_ch.msg_length == LEN_FULL);
	assign msg_on    = len_ok && (status_hi == ST_NOTE_ON) && (in_d2 != '0);
	assign msg_off   = len_ok && ((status_hi == ST_NOTE_OFF) ||
		((status_hi == ST_NOTE_ON) && (in_d2 == '0)));
	assign msg_all   = len_ok && (status_hi == ST_CTRL) &&
		((in_d1 == CC_ALL_SOUND_OFF) || (in_d1 == CC_ALL_NOTES_OFF));
	assign fin_ok    = in_ch.command && ({1'b0, in_ch.finished_voice} < 5'(VOICES));
	assign accept    = in_ch.valid && in_ready;
	assign out_free  = !out_valid_q || out_ch.ready;
	assign any_rel   = |(vf_active & vf_rel);

	// Clamp the cap to 1..VOICES
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CFG_W'(1);
		end else if (cap_q > CFG_W'(VOICES)) begin
			cap_eff = CFG_W'(VOICES);
		end else begin
			cap_eff = cap_q;
		end
	end

	// Choose the voice for a note-on once the scan is done
	always_comb begin
		pick_ok   = 1'b1;
		pick_idx  = scan_res.match_idx;
		pick_kind = KIND_RETRIG;
		if (scan_res.match_found) begin
			pick_idx  = scan_res.match_idx;
			pick_kind = KIND_RETRIG;
		end else if (scan_res.free_found && (scan_res.count < cap_eff)) begin
			pick_idx  = scan_res.free_idx;
			pick_kind = KIND_FREE;
		end else if (scan_res.old_found) begin
			pick_idx  = scan_res.old_idx;
			pick_kind = any_rel ? KIND_STEAL_REL : KIND_STEAL_OLD;
		end else begin
			pick_ok   = 1'b0;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (msg_on || msg_off) ? S_SCAN : S_EMIT;
				end
			end
			S_SCAN: begin
				if (scan_last) begin
					state_d = S_WRAP;
				end
			end
			S_WRAP: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_ready             = 1'b0;
		scan_ctl             = '0;
		scan_ctl.note_on     = mode_on_q;
		vf_cmd               = '0;
		vf_cmd.launch_idx    = pick_idx;
		vf_cmd.launch_note   = d1_q;
		vf_cmd.rel_idx       = IDX_W'(scan_idx);
		vf_cmd.finish_idx    = in_ch.finished_voice;
		case (state_q)
			S_IDLE: begin
				in_ready       = 1'b1;
				scan_ctl.clear = accept;
				vf_cmd.finish  = accept && fin_ok;
				vf_cmd.rel_all = accept && msg_all;
			end
			S_SCAN: begin
				scan_ctl.step  = 1'b1;
				vf_cmd.rel_one = scan_hit;
			end
			S_WRAP: begin
				vf_cmd.launch = mode_on_q && pick_ok;
			end
			S_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			mode_on_q <= 1'b0;
			cap_q     <= CAP_RESET;
		end else begin
			state_q <= state_d;
			if (accept) begin
				mode_on_q <= msg_on;
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				cap_q <= cfg_ch.data;
			end
		end
	end

	// Build the pending result
	always_ff @(posedge clk) begin
		if (accept) begin
			d1_q         <= in_d1;
			d2_q         <= in_d2;
			res_idx_q    <= '0;
			res_note_q   <= '0;
			res_vel_q    <= '0;
			res_kind_q   <= KIND_FREE;
			res_mask_q   <= msg_all ? MASK_W'(vf_active) : '0;
			res_action_q <= (msg_all && (vf_active != '0)) ? ACT_RELEASE : ACT_NONE;
		end else if (state_q == S_WRAP) begin
			if (mode_on_q) begin
				res_mask_q <= '0;
				if (pick_ok) begin
					res_action_q <= ACT_START;
					res_idx_q    <= pick_idx;
					res_note_q   <= d1_q;
					res_vel_q    <= d2_q;
					res_kind_q   <= pick_kind;
				end else begin
					res_action_q <= ACT_NONE;
				end
			end else begin
				res_mask_q   <= MASK_W'(scan_mask);
				res_action_q <= (scan_mask != '0) ? ACT_RELEASE : ACT_NONE;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_EMIT) && out_free) begin
			out_action_q <= res_action_q;
			out_idx_q    <= res_idx_q;
			out_note_q   <= res_note_q;
			out_vel_q    <= res_vel_q;
			out_kind_q   <= res_kind_q;
			out_mask_q   <= res_mask_q;
		end
	end

	assign in_ch.ready            = in_ready;
	assign cfg_ch.ready           = 1'b1;
	assign out_ch.valid           = out_valid_q;
	assign out_ch.action          = out_action_q;
	assign out_ch.voice_index     = out_idx_q;
	assign out_ch.note_number     = out_note_q;
	assign out_ch.strike_velocity = out_vel_q;
	assign out_ch.start_kind      = out_kind_q;
	assign out_ch.release_mask    = out_mask_q;

	sva_voice_file #(
		.VOICES (VOICES)
	) u_voices (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (vf_cmd),
		.rd_idx    (scan_idx),
		.rd        (vf_rd),
		.active    (vf_active),
		.releasing (vf_rel)
	);

	sva_scan_unit #(
		.VOICES (VOICES)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.key_note (d1_q),
		.any_rel  (any_rel),
		.rd       (vf_rd),
		.scan_idx (scan_idx),
		.last     (scan_last),
		.hit      (scan_hit),
		.res      (scan_res),
		.mask     (scan_mask)
	);

	assign launch_i = vf_cmd.launch_idx[VW-1:0];

	// A started voice is active on the next cycle
	a_launch_active: assert property (@(posedge clk) disable iff (!arst_n)
		vf_cmd.launch |=> vf_active[$past(launch_i)])
		else $error("started voice not active");

	// A start word always carries a nonzero velocity
	a_start_vel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_action_q == ACT_START) |-> (out_vel_q != '0))
		else $error("start without velocity");

	// The release mask is empty unless voices were released
	a_mask_only_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_action_q != ACT_RELEASE) |-> (out_mask_q == '0))
		else $error("release mask on non-release word");

	// A note-off release word names only voices that are releasing
	a_mask_releasing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRAP) && !mode_on_q |=>
			((res_mask_q & ~MASK_W'(vf_rel)) == '0))
		else $error("released voice not marked releasing");

endmodule

@@ dv/synth_voice_allocator_test.sv @@
// ----------------------------------------------------------------------------
// synth_voice_allocator_test
// Self-checking bench for the voice allocator. A scoreboard class keeps its
// own copy of the voice table and predicts one result word per input word.
// A directed opening hits the message types and corner cases. Random phases
// of well-formed note traffic, mixed with noise, run under several voice cap
// settings while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module synth_voice_allocator_test import sva_pkg::*; ();

	localparam int NVOICE         = VOICES_DEF;
	localparam int HOLD_CYCLES    = 400;
	localparam int IDLE_LIMIT     = 4000;
	localparam int PHASE_WORDS    = 110;
	localparam int NUM_PHASES     = 8;
	localparam int SETTLE_CYCLES  = 40;
	localparam logic CMD_MIDI     = 1'b0;
	localparam logic CMD_FINISHED = 1'b1;

	typedef struct packed {
		logic       command;
		logic [7:0] status_byte;
		logic [7:0] data_one;
		logic [7:0] data_two;
		logic [1:0] msg_length;
		logic [3:0] finished_voice;
	} midi_word_t;

	typedef struct packed {
		action_t           action;
		logic [IDX_W-1:0]  voice_index;
		logic [NOTE_W-1:0] note_number;
		logic [VEL_W-1:0]  strike_velocity;
		kind_t             start_kind;
		logic [MASK_W-1:0] release_mask;
	} alloc_result_t;

	// Voice table predictor and queue of expected decisions
	class alloc_scoreboard;
		bit                 active [NVOICE];
		bit                 releasing [NVOICE];
		logic [NOTE_W-1:0]  note [NVOICE];
		logic [STAMP_W-1:0] stamp [NVOICE];
		logic [STAMP_W-1:0] start_count;
		logic [CFG_W-1:0]   cap;
		alloc_result_t      expected_q[$];
		int                 errors;
		int                 words;
		int                 kind_count [4];
		int                 release_count;

		function new();
			for (int v = 0; v < NVOICE; v++) begin
				active[v] = 0;
				releasing[v] = 0;
				note[v] = '0;
				stamp[v] = '0;
			end
			start_count = '0;
			cap = CAP_RESET;
			errors = 0;
			words = 0;
			release_count = 0;
			for (int k = 0; k < 4; k++) kind_count[k] = 0;
		endfunction

		function void write_cap(logic [CFG_W-1:0] value);
			cap = value;
		endfunction

		// Clamp the cap to 1..voices
		function int cap_limit();
			int c;
			c = cap;
			if (c < 1) c = 1;
			if (c > NVOICE) c = NVOICE;
			return c;
		endfunction

		function int oldest(bit releasing_only);
			int pick;
			logic [STAMP_W-1:0] best;
			pick = -1;
			best = '0;
			for (int v = 0; v < NVOICE; v++) begin
				if (active[v] && (!releasing_only || releasing[v])) begin
					if (pick < 0 || stamp[v] < best) begin
						pick = v;
						best = stamp[v];
					end
				end
			end
			return pick;
		endfunction

		function logic [MASK_W-1:0] release_voices(bit all, logic [NOTE_W-1:0] n);
			logic [MASK_W-1:0] mask;
			mask = '0;
			for (int v = 0; v < NVOICE; v++) begin
				if (active[v] && (all || note[v] == n)) begin
					releasing[v] = 1;
					mask[v] = 1'b1;
				end
			end
			return mask;
		endfunction

		// Random releasing voice, sometimes any voice at all
		function logic [3:0] pick_releasing();
			int cands[$];
			for (int v = 0; v < NVOICE; v++)
				if (active[v] && releasing[v]) cands.push_back(v);
			if (cands.size() == 0 || $urandom_range(7) == 0)
				return 4'($urandom_range(15));
			return 4'(cands[$urandom_range(cands.size() - 1)]);
		endfunction

		// Update the voice table for an accepted word and queue its decision
		function void note_word(midi_word_t w);
			alloc_result_t r;
			logic [NOTE_W-1:0] d1;
			logic [VEL_W-1:0] d2;
			logic [MASK_W-1:0] mask;
			int pick;
			int free_v;
			int count;
			r.action = ACT_NONE;
			r.voice_index = '0;
			r.note_number = '0;
			r.strike_velocity = '0;
			r.start_kind = KIND_FREE;
			r.release_mask = '0;
			d1 = w.data_one[6:0];
			d2 = w.data_two[6:0];
			mask = '0;
			words++;
			if (w.command == CMD_FINISHED) begin
				if (active[w.finished_voice] && releasing[w.finished_voice]) begin
					active[w.finished_voice] = 0;
					releasing[w.finished_voice] = 0;
				end
			end else if (w.msg_length == LEN_FULL) begin
				if (w.status_byte[7:4] == ST_NOTE_ON && d2 != 0) begin
					pick = -1;
					free_v = -1;
					count = 0;
					for (int v = 0; v < NVOICE; v++) begin
						if (active[v]) begin
							count++;
							if (pick < 0 && note[v] == d1) pick = v;
						end else if (free_v < 0) begin
							free_v = v;
						end
					end
					if (pick >= 0) begin
						r.start_kind = KIND_RETRIG;
					end else if (free_v >= 0 && count < cap_limit()) begin
						pick = free_v;
						r.start_kind = KIND_FREE;
					end else begin
						pick = oldest(1);
						r.start_kind = KIND_STEAL_REL;
						if (pick < 0) begin
							pick = oldest(0);
							r.start_kind = KIND_STEAL_OLD;
						end
					end
					// Launch the chosen voice with a fresh stamp
					start_count = start_count + 1;
					active[pick] = 1;
					releasing[pick] = 0;
					note[pick] = d1;
					stamp[pick] = start_count;
					r.action = ACT_START;
					r.voice_index = 4'(pick);
					r.note_number = d1;
					r.strike_velocity = d2;
					kind_count[r.start_kind]++;
				end else if (w.status_byte[7:4] == ST_NOTE_OFF ||
						w.status_byte[7:4] == ST_NOTE_ON) begin
					mask = release_voices(0, d1);
				end else if (w.status_byte[7:4] == ST_CTRL &&
						(d1 == CC_ALL_SOUND_OFF || d1 == CC_ALL_NOTES_OFF)) begin
					mask = release_voices(1, '0);
				end
				if (r.action == ACT_NONE && mask != 0) begin
					r.action = ACT_RELEASE;
					r.release_mask = mask;
					release_count++;
				end
			end
			expected_q.push_back(r);
		endfunction

		// Compare a result word with the oldest expectation
		function void check_result(alloc_result_t got);
			alloc_result_t exp;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word: act=%0d idx=%0d note=%0d vel=%0d kind=%0d mask=%h",
						got.action, got.voice_index, got.note_number, got.strike_velocity,
						got.start_kind, got.release_mask);
				return;
			end
			exp = expected_q.pop_front();
			if (got.action !== exp.action || got.voice_index !== exp.voice_index ||
					got.note_number !== exp.note_number ||
					got.strike_velocity !== exp.strike_velocity ||
					got.start_kind !== exp.start_kind ||
					got.release_mask !== exp.release_mask) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch expected: act=%0d idx=%0d note=%0d vel=%0d kind=%0d mask=%h",
						exp.action, exp.voice_index, exp.note_number, exp.strike_velocity,
						exp.start_kind, exp.release_mask);
					$display("         actual:   act=%0d idx=%0d note=%0d vel=%0d kind=%0d mask=%h",
						got.action, got.voice_index, got.note_number, got.strike_velocity,
						got.start_kind, got.release_mask);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   steady;
	bit   hold_off_req;
	int   idle_cycles;
	int   cap_writes;

	alloc_scoreboard sb;

	sva_in_if  in_ch();
	sva_out_if out_ch();
	sva_cfg_if cfg_ch();

	synth_voice_allocator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	// Clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Sample every handshake at the rising edge
	always @(posedge clk) begin
		alloc_result_t got;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got.action = out_ch.action;
				got.voice_index = out_ch.voice_index;
				got.note_number = out_ch.note_number;
				got.strike_velocity = out_ch.strike_velocity;
				got.start_kind = out_ch.start_kind;
				got.release_mask = out_ch.release_mask;
				sb.check_result(got);
			end
			if (in_ch.valid && in_ch.ready) begin
				sb.note_word('{in_ch.command, in_ch.status_byte, in_ch.data_one,
					in_ch.data_two, in_ch.msg_length, in_ch.finished_voice});
			end
			if (cfg_ch.valid && cfg_ch.ready) sb.write_cap(cfg_ch.data);
		end
	end

	// Watchdog: end the run after too long without any word moving
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Result receiver: random stalls, one long hold-off on request
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off_req = 0;
			end
			out_ch.ready = arst_n && (steady || $urandom_range(99) >= 16);
		end
	end

	// Offer one word and hold it until taken
	task automatic send_word(midi_word_t w);
		in_ch.command = w.command;
		in_ch.status_byte = w.status_byte;
		in_ch.data_one = w.data_one;
		in_ch.data_two = w.data_two;
		in_ch.msg_length = w.msg_length;
		in_ch.finished_voice = w.finished_voice;
		in_ch.valid = 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	// Drop valid for a random number of cycles
	task automatic sender_gap();
		while (!steady && $urandom_range(99) < 16) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
	endtask

	// Wait until every expected result has come back
	task automatic drain();
		in_ch.valid = 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
	endtask

	task automatic write_voice_cap(logic [CFG_W-1:0] value);
		cfg_ch.data = value;
		cfg_ch.valid = 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
		cap_writes++;
	endtask

	function automatic midi_word_t midi(logic [7:0] st, logic [7:0] d1, logic [7:0] d2,
			logic [1:0] len);
		return '{CMD_MIDI, st, d1, d2, len, 4'd0};
	endfunction

	function automatic midi_word_t finished(logic [3:0] v);
		return '{CMD_FINISHED, 8'h00, 8'h00, 8'h00, 2'd0, v};
	endfunction

	// Mostly well-formed note traffic on a small pool of notes, plus noise
	function automatic midi_word_t random_word(int note_base);
		midi_word_t w;
		int sel;
		sel = $urandom_range(99);
		w.command = CMD_MIDI;
		w.msg_length = LEN_FULL;
		w.status_byte = {ST_NOTE_ON, 4'($urandom_range(15))};
		w.data_one = {1'($urandom_range(1)), 7'(note_base + $urandom_range(11))};
		w.data_two = {1'($urandom_range(1)), 7'($urandom_range(1, 127))};
		w.finished_voice = 4'($urandom_range(15));
		if (sel < 45) begin
			// note-on as built
		end else if (sel < 62) begin
			if ($urandom_range(1)) w.status_byte[7:4] = ST_NOTE_OFF;
			else w.data_two[6:0] = '0;
		end else if (sel < 80) begin
			w.command = CMD_FINISHED;
			w.finished_voice = sb.pick_releasing();
		end else if (sel < 84) begin
			w.status_byte[7:4] = ST_CTRL;
			w.data_one[6:0] = $urandom_range(1) ? CC_ALL_SOUND_OFF : CC_ALL_NOTES_OFF;
		end else begin
			w = midi_word_t'({$urandom, $urandom});
		end
		return w;
	endfunction

	// Main sequence
	initial begin
		logic [CFG_W-1:0] caps [NUM_PHASES];
		int note_base;
		sb = new();
		arst_n = 1'b0;
		steady = 0;
		hold_off_req = 0;
		idle_cycles = 0;
		cap_writes = 0;
		in_ch.valid = 1'b0;
		in_ch.command = CMD_MIDI;
		in_ch.status_byte = '0;
		in_ch.data_one = '0;
		in_ch.data_two = '0;
		in_ch.msg_length = '0;
		in_ch.finished_voice = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = CAP_RESET;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: message types and corner cases under the reset cap
		send_word(midi(8'h90, 8'h00, 8'h01, LEN_FULL));  // lowest note and velocity
		send_word(midi(8'h9F, 8'hFF, 8'hFF, LEN_FULL));  // highest, upper bits ignored
		send_word(midi(8'h93, 8'h00, 8'h40, LEN_FULL));  // retrigger same note
		send_word(midi(8'h9F, 8'h3C, 8'h80, LEN_FULL));  // zero velocity, no match
		send_word(midi(8'h80, 8'h7F, 8'h00, LEN_FULL));  // note-off
		send_word(midi(8'h8A, 8'hFF, 8'h7F, LEN_FULL));  // release again
		send_word(finished(4'd1));                       // frees a releasing voice
		send_word(finished(4'd5));                       // idle voice, ignored
		send_word(finished(4'd0));                       // not releasing, ignored
		send_word(midi(8'h90, 8'h20, 8'h20, 2'd2));      // short message
		send_word(midi(8'h90, 8'h21, 8'h20, 2'd0));
		send_word(midi(8'hA0, 8'h00, 8'h10, LEN_FULL));  // other status
		send_word(midi(8'hB0, 8'h07, 8'h10, LEN_FULL));  // other controller
		send_word(midi(8'hB5, 8'h78, 8'h00, LEN_FULL));  // all sound off
		send_word(midi(8'h90, 8'h28, 8'h7F, LEN_FULL));
		send_word(midi(8'hBF, 8'hFB, 8'hFF, LEN_FULL));  // all notes off
		send_word(midi(8'hF0, 8'h28, 8'h7F, LEN_FULL));
		send_word(midi(8'h00, 8'h28, 8'h7F, LEN_FULL));
		drain();

		// Directed: stealing with a cap of two
		write_voice_cap(5'd2);
		send_word(midi(8'h90, 8'h0A, 8'h10, LEN_FULL));
		send_word(midi(8'h90, 8'h0B, 8'h11, LEN_FULL));
		send_word(midi(8'h90, 8'h0C, 8'h12, LEN_FULL));  // steal oldest active
		send_word(midi(8'h80, 8'h0B, 8'h00, LEN_FULL));
		send_word(midi(8'h90, 8'h0D, 8'h13, LEN_FULL));  // steal the releasing one
		drain();

		// Random phases, one per cap setting
		caps = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd4, 5'd16, 5'($urandom_range(2, 15)), 5'd8};
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_voice_cap(caps[p]);
			steady = (p == 3);
			note_base = $urandom_range(0, 116);
			for (int i = 0; i < PHASE_WORDS; i++) begin
				// Back up the result side while words keep coming
				if (p == 2 && i == 40) hold_off_req = 1;
				// Let the block run dry once mid-phase
				if (p == 4 && i == 50) drain();
				send_word(random_word(note_base));
				sender_gap();
			end
			drain();
		end
		steady = 0;

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Ran %0d words over %0d cap settings with random stalls and a long hold-off.",
			sb.words, cap_writes);
		$display("Starts free/retrigger/steal-releasing/steal-oldest: %0d/%0d/%0d/%0d, releases: %0d",
			sb.kind_count[KIND_FREE], sb.kind_count[KIND_RETRIG],
			sb.kind_count[KIND_STEAL_REL], sb.kind_count[KIND_STEAL_OLD], sb.release_count);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/sva_pkg.sv
src/sva_in_if.sv
src/sva_out_if.sv
src/sva_cfg_if.sv
src/sva_voice_file.sv
src/sva_scan_unit.sv
src/synth_voice_allocator.sv
dv/synth_voice_allocator_test.sv
